// ===== hdl/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// Shared constants, types and helper functions for the allpass fractional
// delay block.
// ----------------------------------------------------------------------------
package afd_pkg;

   localparam int DEPTH    = 4096;
   localparam int CHANNELS = 2;

   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W    = CH_W + PTR_W;
   localparam int RAM_WORDS = 2 ** ADDR_W;

   localparam int SAMPLE_W = 24;
   localparam int GAIN_W   = 17;
   localparam int BASE_W   = 12;
   localparam int OVR_W    = 20;
   localparam int FRAC_W   = 8;
   localparam int DLY_W    = (PTR_W + FRAC_W > OVR_W) ? PTR_W + FRAC_W : OVR_W;

   localparam int MUL_A_W = SAMPLE_W + 1;
   localparam int MUL_B_W = GAIN_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = SAMPLE_W + FRAC_W + 2;
   localparam int SAT_W   = 48;

   localparam logic [GAIN_W-1:0] GAIN_ONE       = GAIN_W'(65536);
   localparam logic [BASE_W-1:0] BASE_DELAY_RST = BASE_W'(1);
   localparam logic [DLY_W-1:0]  DLY_LO         = DLY_W'(256);
   localparam logic [DLY_W-1:0]  DLY_HI         = DLY_W'((DEPTH - 1) * 256);
   localparam logic [PTR_W:0]    DEPTH_X        = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0]  PTR_LAST       = PTR_W'(DEPTH - 1);

   localparam logic signed [SAT_W-1:0] SMAX = SAT_W'(8388607);
   localparam logic signed [SAT_W-1:0] SMIN = -SAT_W'(8388608);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [PTR_W-1:0]           ptr_type;

   typedef enum logic [0:0] {
      REG_GAIN       = 1'b0,
      REG_BASE_DELAY = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_PUSH,
      ST_TAP_FAR,
      ST_TAP_NEAR,
      ST_ROUND,
      ST_GAIN,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MAC_IDLE,
      MAC_TAP_FAR,
      MAC_TAP_NEAR,
      MAC_ROUND,
      MAC_GAIN
   } mac_op_type;

   typedef struct packed {
      mac_op_type           op;
      sample_type           tap;
      logic [FRAC_W-1:0]    frac;
   } mac_ctrl_type;

   function automatic sample_type sat24(input logic signed [SAT_W-1:0] v);
      sample_type r;
      if (v > SMAX) begin
         r = SMAX[SAMPLE_W-1:0];
      end else if (v < SMIN) begin
         r = SMIN[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // (a - b) modulo DEPTH, both operands below DEPTH
   function automatic ptr_type wrap_sub(input ptr_type a, input ptr_type b);
      logic [PTR_W:0] diff;
      logic [PTR_W:0] fix;
      diff = {1'b0, a} - {1'b0, b};
      fix  = diff + DEPTH_X;
      return diff[PTR_W] ? fix[PTR_W-1:0] : diff[PTR_W-1:0];
   endfunction

endpackage

// ===== hdl/afd_ram.sv =====
// ----------------------------------------------------------------------------
// afd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module afd_ram #(
   parameter int WIDTH = 24,
   parameter int WORDS = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(WORDS)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(WORDS)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/afd_mac.sv =====
// ----------------------------------------------------------------------------
// afd_mac
// Shared multiply-accumulate unit: interpolates the two taps, rounds the
// read value and scales it by the loop gain.
// ----------------------------------------------------------------------------
module afd_mac (
   input  logic                          clock,
   input  afd_pkg::mac_ctrl_type         ctrl,
   input  logic [afd_pkg::GAIN_W-1:0]    gain,
   output afd_pkg::sample_type           rd,
   output afd_pkg::sample_type           fb
);

   localparam logic signed [afd_pkg::ACC_W-1:0]  HALF_TAP  = afd_pkg::ACC_W'(128);
   localparam logic signed [afd_pkg::PROD_W-1:0] HALF_GAIN = afd_pkg::PROD_W'(32768);

   logic signed [afd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [afd_pkg::MUL_B_W-1:0] mul_b;
   logic signed [afd_pkg::PROD_W-1:0]  prod_in;
   logic signed [afd_pkg::PROD_W-1:0]  prod_ff;
   logic signed [afd_pkg::ACC_W-1:0]   acc_ff;
   logic signed [afd_pkg::ACC_W-1:0]   prod_low;
   logic signed [afd_pkg::ACC_W-1:0]   tap_sum;
   logic signed [afd_pkg::PROD_W-1:0]  gain_sum;
   afd_pkg::sample_type                rd_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         afd_pkg::MAC_TAP_FAR: begin
            mul_a = afd_pkg::MUL_A_W'(ctrl.tap);
            mul_b = afd_pkg::MUL_B_W'({1'b0, ctrl.frac});
         end
         afd_pkg::MAC_TAP_NEAR: begin
            mul_a = afd_pkg::MUL_A_W'(ctrl.tap);
            mul_b = afd_pkg::MUL_B_W'(9'd256 - {1'b0, ctrl.frac});
         end
         afd_pkg::MAC_GAIN: begin
            mul_a = afd_pkg::MUL_A_W'(rd_ff);
            mul_b = afd_pkg::MUL_B_W'(gain);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_low = $signed(prod_ff[afd_pkg::ACC_W-1:0]);
   assign tap_sum  = acc_ff + prod_low;
   assign gain_sum = prod_ff + HALF_GAIN;

   always_ff @(posedge clock) begin
      if (ctrl.op inside {afd_pkg::MAC_TAP_FAR, afd_pkg::MAC_TAP_NEAR, afd_pkg::MAC_GAIN}) begin
         prod_ff <= prod_in;
      end
      if (ctrl.op == afd_pkg::MAC_TAP_NEAR) begin
         acc_ff <= prod_low + HALF_TAP;
      end
      if (ctrl.op == afd_pkg::MAC_ROUND) begin
         rd_ff <= afd_pkg::sat24(afd_pkg::SAT_W'(tap_sum >>> afd_pkg::FRAC_W));
      end
   end

   assign rd = rd_ff;
   assign fb = afd_pkg::sat24(afd_pkg::SAT_W'(gain_sum >>> 16));

endmodule

// ===== hdl/allpass_fractional_delay.sv =====
// ----------------------------------------------------------------------------
// allpass_fractional_delay
// Multichannel allpass filter on a circular delay line with a linearly
// interpolated fractional read.
//
// The req channel takes one word per sample (channel, sample, optional
// 12.8 delay override); the rsp channel returns one filtered sample per
// word on a channel in range. Both use valid/stall handshakes.
// The csr port writes gain (index 0) and base_delay (index 1); the user
// must write them only while idle, the block does not enforce it. A word runs
// through a sequencer after acceptance: delay clamp, push write with the far
// tap read, near tap read, two products on the shared multiplier, rounding,
// gain product, output. req_stall is held meanwhile, so a word is taken only
// after the last leaves, as all steps share one multiplier and RAM read port.
// The result sits in an output register; a stalled rsp holds the sequencer
// in its last step, and req_stall stays high until the word moves on.
// Reset clears pointers, feedback and registers at once; a per-channel fill
// mark makes unwritten delay entries read as zero, so no clearing pass.
// ----------------------------------------------------------------------------
module allpass_fractional_delay (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [0:0]                         csr_index,
   input  logic [afd_pkg::GAIN_W-1:0]         csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_channel,
   input  logic signed [afd_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                               req_use_override,
   input  logic [afd_pkg::OVR_W-1:0]          req_override_delay,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [afd_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   afd_pkg::state_type state_ff;
   afd_pkg::state_type state_in;

   logic [afd_pkg::GAIN_W-1:0] gain_ff;
   logic [afd_pkg::BASE_W-1:0] base_ff;

   logic [afd_pkg::CH_W-1:0]   ch_ff;
   afd_pkg::sample_type        x_ff;
   logic                       use_ov_ff;
   logic [afd_pkg::OVR_W-1:0]  ovr_ff;

   afd_pkg::ptr_type           wp_ff   [afd_pkg::CHANNELS];
   logic                       full_ff [afd_pkg::CHANNELS];
   afd_pkg::sample_type        fb_ff   [afd_pkg::CHANNELS];

   afd_pkg::ptr_type           dint_ff;
   logic [afd_pkg::FRAC_W-1:0] frac_ff;
   afd_pkg::sample_type        push_ff;
   afd_pkg::ptr_type           wpn_ff;
   afd_pkg::ptr_type           i1_ff;
   logic                       v1_ff;
   logic                       v2_ff;

   logic                       rsp_valid_ff;
   afd_pkg::sample_type        rsp_data_ff;

   logic                       accept;
   logic                       ch_ok;
   logic                       out_load;
   afd_pkg::ptr_type           wp_cur;
   logic                       full_cur;
   logic                       full_new;
   afd_pkg::ptr_type           i2;
   afd_pkg::ptr_type           i1;
   afd_pkg::ptr_type           rd_idx;
   logic                       ram_wr_en;
   logic [afd_pkg::SAMPLE_W-1:0] ram_rd_data;
   logic [afd_pkg::DLY_W-1:0]  dly_raw;
   logic [afd_pkg::DLY_W-1:0]  dly_c;
   afd_pkg::mac_ctrl_type      mac_ctrl;
   afd_pkg::sample_type        mac_rd;
   afd_pkg::sample_type        mac_fb;
   logic signed [afd_pkg::SAT_W-1:0] out_sum;

   assign ch_ok  = (int'(req_channel) < afd_pkg::CHANNELS);
   assign accept = req_valid && (state_ff == afd_pkg::ST_IDLE);

   assign wp_cur   = wp_ff[ch_ff];
   assign full_cur = full_ff[ch_ff];
   assign full_new = full_cur || (wpn_ff == '0);
   assign i2       = afd_pkg::wrap_sub(wp_cur, dint_ff);
   assign i1       = afd_pkg::wrap_sub(wpn_ff, dint_ff);

   // delay select and clamp to 1.0 .. DEPTH-1
   always_comb begin
      if (use_ov_ff) begin
         dly_raw = afd_pkg::DLY_W'(ovr_ff);
      end else begin
         dly_raw = afd_pkg::DLY_W'({base_ff, 8'h00});
      end
      if (dly_raw < afd_pkg::DLY_LO) begin
         dly_c = afd_pkg::DLY_LO;
      end else if (dly_raw > afd_pkg::DLY_HI) begin
         dly_c = afd_pkg::DLY_HI;
      end else begin
         dly_c = dly_raw;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_stall     = (state_ff != afd_pkg::ST_IDLE);
      ram_wr_en     = 1'b0;
      rd_idx        = i1_ff;
      out_load      = 1'b0;
      mac_ctrl.op   = afd_pkg::MAC_IDLE;
      mac_ctrl.tap  = '0;
      mac_ctrl.frac = frac_ff;
      case (state_ff)
         afd_pkg::ST_IDLE: begin
            if (req_valid && ch_ok) begin
               state_in = afd_pkg::ST_CALC;
            end
         end
         afd_pkg::ST_CALC: begin
            state_in = afd_pkg::ST_PUSH;
         end
         afd_pkg::ST_PUSH: begin
            ram_wr_en = 1'b1;
            rd_idx    = i2;
            state_in  = afd_pkg::ST_TAP_FAR;
         end
         afd_pkg::ST_TAP_FAR: begin
            mac_ctrl.op  = afd_pkg::MAC_TAP_FAR;
            mac_ctrl.tap = v2_ff ? afd_pkg::sample_type'(ram_rd_data) : '0;
            rd_idx       = i1_ff;
            state_in     = afd_pkg::ST_TAP_NEAR;
         end
         afd_pkg::ST_TAP_NEAR: begin
            mac_ctrl.op  = afd_pkg::MAC_TAP_NEAR;
            mac_ctrl.tap = v1_ff ? afd_pkg::sample_type'(ram_rd_data) : '0;
            state_in     = afd_pkg::ST_ROUND;
         end
         afd_pkg::ST_ROUND: begin
            mac_ctrl.op = afd_pkg::MAC_ROUND;
            state_in    = afd_pkg::ST_GAIN;
         end
         afd_pkg::ST_GAIN: begin
            mac_ctrl.op = afd_pkg::MAC_GAIN;
            state_in    = afd_pkg::ST_OUT;
         end
         afd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = afd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = afd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= afd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= '0;
         base_ff <= afd_pkg::BASE_DELAY_RST;
      end else if (csr_write_enable) begin
         case (afd_pkg::reg_index_type'(csr_index))
            afd_pkg::REG_GAIN: begin
               gain_ff <= (csr_write_data > afd_pkg::GAIN_ONE) ? afd_pkg::GAIN_ONE
                                                               : csr_write_data;
            end
            afd_pkg::REG_BASE_DELAY: begin
               base_ff <= csr_write_data[afd_pkg::BASE_W-1:0];
            end
            default: begin
               base_ff <= base_ff;
            end
         endcase
      end
   end

   // input word capture and per-step payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff     <= afd_pkg::CH_W'(req_channel);
         x_ff      <= req_sample_in;
         use_ov_ff <= req_use_override;
         ovr_ff    <= req_override_delay;
      end
      if (state_ff == afd_pkg::ST_CALC) begin
         dint_ff <= dly_c[afd_pkg::PTR_W+afd_pkg::FRAC_W-1:afd_pkg::FRAC_W];
         frac_ff <= dly_c[afd_pkg::FRAC_W-1:0];
         push_ff <= afd_pkg::sat24(afd_pkg::SAT_W'(x_ff) + afd_pkg::SAT_W'(fb_ff[ch_ff]));
         wpn_ff  <= (wp_cur == afd_pkg::PTR_LAST) ? '0 : wp_cur + 1'b1;
      end
      if (state_ff == afd_pkg::ST_PUSH) begin
         i1_ff <= i1;
         // entry holds data once written since reset
         v2_ff <= full_new || (i2 < wpn_ff);
      end
      if (state_ff == afd_pkg::ST_TAP_FAR) begin
         v1_ff <= full_cur || (i1_ff < wp_cur);
      end
   end

   // per-channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < afd_pkg::CHANNELS; c++) begin
            wp_ff[c]   <= '0;
            full_ff[c] <= 1'b0;
            fb_ff[c]   <= '0;
         end
      end else begin
         if (state_ff == afd_pkg::ST_PUSH) begin
            wp_ff[ch_ff]   <= wpn_ff;
            full_ff[ch_ff] <= full_new;
         end
         if (out_load) begin
            fb_ff[ch_ff] <= mac_fb;
         end
      end
   end

   // output register
   assign out_sum = afd_pkg::SAT_W'(mac_rd) - afd_pkg::SAT_W'(x_ff)
                    - afd_pkg::SAT_W'(mac_fb);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= afd_pkg::sat24(out_sum);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   afd_ram #(
      .WIDTH (afd_pkg::SAMPLE_W),
      .WORDS (afd_pkg::RAM_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr ({ch_ff, wp_cur}),
      .wr_data (push_ff),
      .rd_addr ({ch_ff, rd_idx}),
      .rd_data (ram_rd_data)
   );

   afd_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .gain  (gain_ff),
      .rd    (mac_rd),
      .fb    (mac_fb)
   );

`ifndef NO_ASSERTIONS
   a_rsp_from_seq : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == afd_pkg::ST_OUT))
      else $error("result word appeared outside the output step");

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      (accept && ch_ok) |=> (state_ff == afd_pkg::ST_CALC))
      else $error("accepted word did not start the sequence");

   a_delay_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == afd_pkg::ST_PUSH) |->
         (dint_ff != '0) && (int'(dint_ff) <= afd_pkg::DEPTH - 1))
      else $error("clamped delay out of range");

   a_no_collision : assert property (@(posedge clock) disable iff (reset)
      (state_ff == afd_pkg::ST_PUSH) |-> (i2 != wp_cur))
      else $error("far tap read hits the entry being written");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the allpass fractional delay block. A queue of
// sample words feeds a valid/stall driver; every accepted word runs through a
// local model of the allpass filter, and each returned sample is compared
// with the oldest prediction. Gain and base delay change between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_WORDS    = 190;

   typedef struct packed {
      logic                          channel;
      afd_pkg::sample_type           sample;
      logic                          use_override;
      logic [afd_pkg::OVR_W-1:0]     override_delay;
   } filter_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [0:0]                    csr_index = afd_pkg::REG_GAIN;
   logic [afd_pkg::GAIN_W-1:0]    csr_write_data = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_channel = 1'b0;
   afd_pkg::sample_type           req_sample_in = '0;
   logic                          req_use_override = 1'b0;
   logic [afd_pkg::OVR_W-1:0]     req_override_delay = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   afd_pkg::sample_type           rsp_sample_out;

   allpass_fractional_delay dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_channel        (req_channel),
      .req_sample_in      (req_sample_in),
      .req_use_override   (req_use_override),
      .req_override_delay (req_override_delay),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // filter model state
   afd_pkg::sample_type        delay_line [afd_pkg::CHANNELS][afd_pkg::DEPTH];
   longint                     wr_ptr [afd_pkg::CHANNELS];
   afd_pkg::sample_type        loop_fb [afd_pkg::CHANNELS];
   logic [afd_pkg::GAIN_W-1:0] gain_q16;
   logic [afd_pkg::BASE_W-1:0] base_dly;

   filter_word_type     pending_words [$];
   afd_pkg::sample_type expected_out [$];
   int           words_queued = 0;
   int           words_taken = 0;
   int           results_seen = 0;
   int           error_count = 0;
   int           idle_cycles = 0;
   int           phases_run = 0;
   logic         word_accepted = 1'b0;
   logic         quiet = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;

   function automatic afd_pkg::sample_type clip24(input longint v);
      if (v > 64'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -64'sd8388608) begin
         return 24'sh800000;
      end
      return v[afd_pkg::SAMPLE_W-1:0];
   endfunction

   // push then interpolated pop; updates the model state
   function automatic afd_pkg::sample_type allpass_predict(input filter_word_type w);
      longint ch;
      longint wp;
      longint dly;
      longint dint;
      longint frac;
      longint acc;
      afd_pkg::sample_type s1;
      afd_pkg::sample_type s2;
      afd_pkg::sample_type rd;
      afd_pkg::sample_type fb;
      ch = longint'(w.channel);
      wp = wr_ptr[ch];
      delay_line[ch][wp] = clip24(longint'(w.sample) + longint'(loop_fb[ch]));
      wp = (wp + 1) % afd_pkg::DEPTH;
      wr_ptr[ch] = wp;
      if (w.use_override) begin
         dly = longint'(w.override_delay);
      end else begin
         dly = longint'(base_dly) * 256;
      end
      if (dly < 256) dly = 256;
      if (dly > longint'(afd_pkg::DEPTH - 1) * 256) dly = longint'(afd_pkg::DEPTH - 1) * 256;
      dint = dly >> 8;
      frac = dly & 255;
      s1 = delay_line[ch][(wp + afd_pkg::DEPTH - dint) % afd_pkg::DEPTH];
      s2 = delay_line[ch][(wp + 2 * afd_pkg::DEPTH - dint - 1) % afd_pkg::DEPTH];
      acc = (256 - frac) * longint'(s1) + frac * longint'(s2) + 128;
      rd = clip24(acc >>> 8);
      fb = clip24((longint'(rd) * longint'(gain_q16) + 32768) >>> 16);
      loop_fb[ch] = fb;
      return clip24(longint'(rd) - longint'(w.sample) - longint'(fb));
   endfunction

   function automatic filter_word_type random_word();
      filter_word_type w;
      w.channel = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: w.sample = 24'sh7FFFFF;
         1: w.sample = 24'sh800000;
         2: w.sample = 24'($urandom_range(0, 255) - 128);
         default: w.sample = 24'($urandom());
      endcase
      w.use_override = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: w.override_delay = 20'($urandom());
         1: w.override_delay = 20'($urandom_range(0, 255));
         2: w.override_delay = 20'($urandom_range((afd_pkg::DEPTH - 1) * 256, 1048575));
         default: w.override_delay = 20'($urandom_range(256, 48 * 256));
      endcase
      return w;
   endfunction

   task automatic add_word(input logic ch, input afd_pkg::sample_type s, input logic ov,
                           input logic [afd_pkg::OVR_W-1:0] od);
      filter_word_type w;
      w.channel = ch;
      w.sample = s;
      w.use_override = ov;
      w.override_delay = od;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic write_csr(input afd_pkg::reg_index_type idx,
                            input logic [afd_pkg::GAIN_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // every queued word has produced its sample
   task automatic wait_drained();
      @(negedge clock);
      while (results_seen != words_queued) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      filter_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !word_accepted) begin
         // stalled word holds
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (pending_words.size() > 0) begin
         w = pending_words.pop_front();
         req_channel <= w.channel;
         req_sample_in <= w.sample;
         req_use_override <= w.use_override;
         req_override_delay <= w.override_delay;
         req_valid <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 13);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // response stall bursts
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         rsp_gap--;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         rsp_gap = $urandom_range(1, 13) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin
      filter_word_type     w;
      afd_pkg::sample_type want;
      word_accepted <= !reset && req_valid && !req_stall;
      if (reset) begin
         for (int c = 0; c < afd_pkg::CHANNELS; c++) begin
            for (int i = 0; i < afd_pkg::DEPTH; i++) delay_line[c][i] = '0;
            wr_ptr[c] = 0;
            loop_fb[c] = '0;
         end
         gain_q16 = '0;
         base_dly = afd_pkg::BASE_DELAY_RST;
      end else begin
         if (csr_write_enable) begin
            case (afd_pkg::reg_index_type'(csr_index))
               afd_pkg::REG_GAIN: begin
                  gain_q16 = (csr_write_data > afd_pkg::GAIN_ONE) ? afd_pkg::GAIN_ONE
                                                                  : csr_write_data;
               end
               afd_pkg::REG_BASE_DELAY: base_dly = csr_write_data[afd_pkg::BASE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            w.channel = req_channel;
            w.sample = req_sample_in;
            w.use_override = req_use_override;
            w.override_delay = req_override_delay;
            expected_out.push_back(allpass_predict(w));
            words_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_out.size() == 0) begin
               $error("sample_out: no word pending, actual %0d", rsp_sample_out);
               error_count++;
            end else begin
               want = expected_out.pop_front();
               results_seen++;
               if (rsp_sample_out !== want) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         want, rsp_sample_out);
                  error_count++;
               end
            end
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [afd_pkg::GAIN_W-1:0] g;
      logic [afd_pkg::BASE_W-1:0] bd;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: no gain, one sample of delay
      add_word(1'b0, 24'sh7FFFFF, 1'b0, '0);
      add_word(1'b0, 24'sh800000, 1'b0, '0);
      add_word(1'b1, 24'sh000000, 1'b1, 20'h00000);
      add_word(1'b1, -24'sd1,     1'b1, 20'h000FF);
      add_word(1'b0, 24'sh000001, 1'b1, 20'h00100);
      add_word(1'b0, 24'sh123456, 1'b1, 20'h00101);
      add_word(1'b1, 24'sh7FFFFF, 1'b1, 20'hFFFFF);
      add_word(1'b1, 24'sh800000, 1'b1, 20'(( afd_pkg::DEPTH - 1) * 256));
      add_word(1'b0, 24'sh3FFFFF, 1'b1, 20'(( afd_pkg::DEPTH - 1) * 256 - 1));
      add_word(1'b0, 24'shC00000, 1'b1, 20'h00380);
      add_word(1'b1, 24'sh555555, 1'b1, 20'h002FF);
      wait_drained();
      phases_run++;

      // gain written above one (clamped to one), zero base delay: push and output saturate
      write_csr(afd_pkg::REG_GAIN, 17'h1FFFF);
      write_csr(afd_pkg::REG_BASE_DELAY, 17'h00000);
      @(posedge clock);
      repeat (3) add_word(1'b0, 24'sh7FFFFF, 1'b0, '0);
      repeat (3) add_word(1'b1, 24'sh800000, 1'b0, '0);
      wait_drained();
      phases_run++;

      write_csr(afd_pkg::REG_GAIN, afd_pkg::GAIN_ONE);
      write_csr(afd_pkg::REG_BASE_DELAY, 17'(afd_pkg::DEPTH - 1));
      @(posedge clock);
      add_word(1'b0, 24'sh7FFFFF, 1'b0, '0);
      add_word(1'b1, 24'sh800000, 1'b0, '0);
      add_word(1'b0, 24'sh000000, 1'b1, 20'h00200);
      add_word(1'b1, 24'sh2AAAAA, 1'b1, 20'h00480);
      wait_drained();
      phases_run++;

      write_csr(afd_pkg::REG_GAIN, 17'h08000);
      write_csr(afd_pkg::REG_BASE_DELAY, 17'h1F002);
      @(posedge clock);
      add_word(1'b0, 24'sh400000, 1'b0, '0);
      add_word(1'b0, 24'shBFFFFF, 1'b0, '0);
      add_word(1'b0, 24'sh000000, 1'b0, '0);
      wait_drained();
      phases_run++;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: g = '0;
            1: g = afd_pkg::GAIN_ONE;
            2: g = 17'($urandom_range(65537, 131071));
            default: g = 17'($urandom_range(0, 65535));
         endcase
         case ($urandom_range(0, 5))
            0: bd = '0;
            1: bd = 12'(afd_pkg::DEPTH - 1);
            default: bd = 12'($urandom_range(1, 40));
         endcase
         write_csr(afd_pkg::REG_GAIN, g);
         write_csr(afd_pkg::REG_BASE_DELAY, {5'($urandom()), bd});
         @(posedge clock);
         // final phase runs back to back on both sides
         if (p == RANDOM_PHASES - 1) quiet = 1'b1;
         for (int k = 0; k < PHASE_WORDS; k++) begin
            pending_words.push_back(random_word());
            words_queued++;
         end
         wait_drained();
         phases_run++;
      end

      repeat (20) @(negedge clock);
      $display("%0d sample words in %0d settings of gain and delay, %0d samples checked",
               words_taken, phases_run, results_seen);
      $display("delays covered from below one sample to the full line, gain 0 to above one");
      if (error_count == 0 && expected_out.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/afd_pkg.sv
hdl/afd_ram.sv
hdl/afd_mac.sv
hdl/allpass_fractional_delay.sv
tb/sv/tb.sv
